[hw/rtl/gyro_angle_kalman_filter_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the gyro angle Kalman filter
// Concurrent assertion shorthands on clk_i, with and without reset masking.
// ---------------------------------------------------------------------------
`ifndef GYRO_ANGLE_KALMAN_FILTER_ASSERT_SVH
`define GYRO_ANGLE_KALMAN_FILTER_ASSERT_SVH

// check only while out of reset
`define GAK_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check at every edge, reset included
`define GAK_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[hw/rtl/gak_pkg.sv]
// ---------------------------------------------------------------------------
// gak_pkg
// Types, codes and helpers shared by the gyro angle Kalman filter modules.
// ---------------------------------------------------------------------------
package gak_pkg;

  localparam int FRACTION_BITS_DEF = 16;
  localparam int DT_BITS   = 16;
  localparam int CFG_W     = 31;
  localparam int CFG_IDX_W = 2;
  localparam int OP_W      = 33;
  localparam int PROD_W    = 2 * OP_W;
  localparam int ACC_W     = PROD_W + 2;
  localparam int NUM_STEPS = 6;
  localparam int STEP_W    = $clog2(NUM_STEPS);

  localparam logic [CFG_W-1:0] ANGLE_NOISE_RST   = CFG_W'(66);
  localparam logic [CFG_W-1:0] BIAS_NOISE_RST    = CFG_W'(197);
  localparam logic [CFG_W-1:0] MEASURE_NOISE_RST = CFG_W'(1966);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ANGLE_NOISE   = 2'd0,
    CFG_BIAS_NOISE    = 2'd1,
    CFG_MEASURE_NOISE = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    CMD_PREDICT = 1'b0,
    CMD_UPDATE  = 1'b1
  } item_cmd_e;

  typedef enum logic [2:0] {
    A_RATE_MB, A_P_SUM, A_QA, A_QB, A_P11, A_K0, A_K1
  } a_sel_e;

  typedef enum logic [1:0] {
    B_DT, B_Y, B_P00, B_P01
  } b_sel_e;

  typedef enum logic [2:0] {
    DST_ANGLE, DST_BIAS, DST_P00, DST_P01, DST_P10, DST_P11
  } dst_e;

  typedef struct packed {
    logic               command;
    logic signed [31:0] gyro_rate;
    logic [15:0]        time_step;
    logic signed [31:0] measured_angle;
  } gak_in_t;

  typedef struct packed {
    logic signed [31:0] angle_estimate;
    logic signed [31:0] bias_estimate;
  } gak_out_t;

  typedef struct packed {
    logic   valid;
    a_sel_e a_sel;
    b_sel_e b_sel;
    dst_e   dst;
    logic   neg;
    logic   first;
    logic   last;
    logic   frac;
  } mul_cmd_t;

  typedef struct packed {
    logic     load;
    logic     div_start;
    logic     out_load;
    mul_cmd_t mul;
  } dp_cmd_t;

  typedef struct packed {
    logic is_update;
    logic s_pos;
    logic div_busy;
  } dp_stat_t;

  function automatic mul_cmd_t mk_cmd(a_sel_e a, b_sel_e b, dst_e d, logic neg,
                                      logic first, logic last, logic frac);
    mul_cmd_t c;
    c.valid = 1'b1;
    c.a_sel = a;
    c.b_sel = b;
    c.dst   = d;
    c.neg   = neg;
    c.first = first;
    c.last  = last;
    c.frac  = frac;
    return c;
  endfunction

  // Multiply-accumulate program for one item. Every register is read before
  // the step that overwrites it.
  function automatic mul_cmd_t step_cmd(logic upd, logic [STEP_W-1:0] step);
    mul_cmd_t c;
    c = '0;
    if (upd) begin
      case (step)
        3'd0:    c = mk_cmd(A_K0, B_Y,   DST_ANGLE, 1'b0, 1'b1, 1'b1, 1'b1);
        3'd1:    c = mk_cmd(A_K1, B_Y,   DST_BIAS,  1'b0, 1'b1, 1'b1, 1'b1);
        3'd2:    c = mk_cmd(A_K1, B_P00, DST_P10,   1'b1, 1'b1, 1'b1, 1'b1);
        3'd3:    c = mk_cmd(A_K1, B_P01, DST_P11,   1'b1, 1'b1, 1'b1, 1'b1);
        3'd4:    c = mk_cmd(A_K0, B_P01, DST_P01,   1'b1, 1'b1, 1'b1, 1'b1);
        3'd5:    c = mk_cmd(A_K0, B_P00, DST_P00,   1'b1, 1'b1, 1'b1, 1'b1);
        default: c = '0;
      endcase
    end else begin
      case (step)
        3'd0:    c = mk_cmd(A_RATE_MB, B_DT, DST_ANGLE, 1'b0, 1'b1, 1'b1, 1'b0);
        3'd1:    c = mk_cmd(A_P_SUM,   B_DT, DST_P00,   1'b1, 1'b1, 1'b0, 1'b0);
        3'd2:    c = mk_cmd(A_QA,      B_DT, DST_P00,   1'b0, 1'b0, 1'b1, 1'b0);
        3'd3:    c = mk_cmd(A_P11,     B_DT, DST_P01,   1'b1, 1'b1, 1'b1, 1'b0);
        3'd4:    c = mk_cmd(A_P11,     B_DT, DST_P10,   1'b1, 1'b1, 1'b1, 1'b0);
        3'd5:    c = mk_cmd(A_QB,      B_DT, DST_P11,   1'b0, 1'b1, 1'b1, 1'b0);
        default: c = '0;
      endcase
    end
    return c;
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [ACC_W-1:0] v);
    logic in_range;
    in_range = (&v[ACC_W-1:31]) | ~(|v[ACC_W-1:31]);
    if (in_range) begin
      return v[31:0];
    end
    return v[ACC_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
  endfunction

endpackage

[hw/rtl/gak_ctrl.sv]
// ---------------------------------------------------------------------------
// gak_ctrl
// Sequencer: takes a word, runs the multiply program (an update runs the divide
// first, or skips both if S is not positive) and hands update results to the output register.
// ---------------------------------------------------------------------------
module gak_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output gak_pkg::dp_cmd_t  cmd_o,
  input  gak_pkg::dp_stat_t stat_i
);
  import gak_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_PREP   = 6'b000010,
    ST_DIVIDE = 6'b000100,
    ST_STEP   = 6'b001000,
    ST_DRAIN  = 6'b010000,
    ST_OUTPUT = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              out_valid_q, out_valid_d;
  logic              out_free;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_PREP;
        end
      end
      ST_PREP: begin
        step_d = '0;
        if (!stat_i.is_update) begin
          state_d = ST_STEP;
        end else if (stat_i.s_pos) begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIVIDE;
        end else begin
          // no correction: report current estimates
          state_d = ST_OUTPUT;
        end
      end
      ST_DIVIDE: begin
        if (!stat_i.div_busy) begin
          state_d = ST_STEP;
        end
      end
      ST_STEP: begin
        cmd_o.mul = step_cmd(stat_i.is_update, step_q);
        step_d    = step_q + STEP_W'(1);
        if (step_q == STEP_W'(NUM_STEPS - 1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = stat_i.is_update ? ST_OUTPUT : ST_IDLE;
      end
      ST_OUTPUT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[hw/rtl/gak_datapath.sv]
// ---------------------------------------------------------------------------
// gak_datapath
// Filter state, noise registers, shared multiply-accumulate unit and a
// two-lane restoring divider for the gains.
// ---------------------------------------------------------------------------
module gak_datapath #(
  parameter int FRACTION_BITS = gak_pkg::FRACTION_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [gak_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [gak_pkg::CFG_W-1:0]       cfg_data_i,
  input  gak_pkg::gak_in_t                in_data_i,
  output gak_pkg::gak_out_t               out_data_o,
  input  gak_pkg::dp_cmd_t                cmd_i,
  output gak_pkg::dp_stat_t               stat_o
);
  import gak_pkg::*;

  localparam int NUM_W = 32 + FRACTION_BITS;
  localparam int CNT_W = $clog2(NUM_W + 1);
  localparam logic signed [ACC_W-1:0] HALF_DT   = ACC_W'(1) <<< (DT_BITS - 1);
  localparam logic signed [ACC_W-1:0] HALF_FRAC = ACC_W'(1) <<< (FRACTION_BITS - 1);

  // noise registers
  logic [CFG_W-1:0] qa_q, qb_q, r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qa_q <= ANGLE_NOISE_RST;
      qb_q <= BIAS_NOISE_RST;
      r_q  <= MEASURE_NOISE_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ANGLE_NOISE:   qa_q <= cfg_data_i;
        CFG_BIAS_NOISE:    qb_q <= cfg_data_i;
        CFG_MEASURE_NOISE: r_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // filter state
  logic signed [31:0] angle_q, bias_q, p00_q, p01_q, p10_q, p11_q;

  // latched item
  logic               upd_q;
  logic signed [31:0] rate_q;
  logic [15:0]        dt_q;
  logic signed [32:0] y_q, s_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upd_q <= 1'b0;
    end else if (cmd_i.load) begin
      upd_q <= (in_data_i.command == CMD_UPDATE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rate_q <= in_data_i.gyro_rate;
      dt_q   <= in_data_i.time_step;
      y_q    <= 33'(in_data_i.measured_angle) - 33'(angle_q);
      s_q    <= 33'(p00_q) + $signed({2'b00, r_q});
    end
  end

  // divider: |P| << FRACTION_BITS over S, both gains at once
  logic [NUM_W-1:0]   n0_q, n1_q;
  logic [31:0]        r0_q, r1_q, d_q;
  logic               neg0_q, neg1_q, busy_q;
  logic [CNT_W-1:0]   cnt_q;
  logic signed [31:0] k0_q, k1_q;
  logic [32:0]        sh0, sh1;
  logic               ge0, ge1;
  logic [31:0]        mag00, mag10;

  assign mag00 = p00_q[31] ? 32'(-p00_q) : p00_q;
  assign mag10 = p10_q[31] ? 32'(-p10_q) : p10_q;
  assign sh0   = {r0_q, n0_q[NUM_W-1]};
  assign sh1   = {r1_q, n1_q[NUM_W-1]};
  assign ge0   = sh0 >= {1'b0, d_q};
  assign ge1   = sh1 >= {1'b0, d_q};

  function automatic logic signed [31:0] sat_quot(logic [NUM_W-1:0] q, logic neg);
    logic big;
    big = |q[NUM_W-1:31];
    if (!neg) begin
      return big ? 32'sh7FFF_FFFF : $signed(q[31:0]);
    end
    if (big && (q != NUM_W'(64'h8000_0000))) begin
      return 32'sh8000_0000;
    end
    return $signed(32'(-q));
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (cmd_i.div_start) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(NUM_W);
    end else if (busy_q) begin
      if (cnt_q != '0) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end else begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      n0_q   <= {mag00, FRACTION_BITS'(0)};
      n1_q   <= {mag10, FRACTION_BITS'(0)};
      r0_q   <= '0;
      r1_q   <= '0;
      d_q    <= s_q[31:0];
      neg0_q <= p00_q[31];
      neg1_q <= p10_q[31];
    end else if (busy_q) begin
      if (cnt_q != '0) begin
        r0_q <= ge0 ? 32'(sh0 - {1'b0, d_q}) : sh0[31:0];
        r1_q <= ge1 ? 32'(sh1 - {1'b0, d_q}) : sh1[31:0];
        n0_q <= {n0_q[NUM_W-2:0], ge0};
        n1_q <= {n1_q[NUM_W-2:0], ge1};
      end else begin
        k0_q <= sat_quot(n0_q, neg0_q);
        k1_q <= sat_quot(n1_q, neg1_q);
      end
    end
  end

  // multiply stage
  logic signed [OP_W-1:0]   a_op, b_op;
  logic signed [PROD_W-1:0] prod_q;
  mul_cmd_t                 mul_q;

  always_comb begin
    case (cmd_i.mul.a_sel)
      A_RATE_MB: a_op = OP_W'(rate_q) - OP_W'(bias_q);
      A_P_SUM:   a_op = OP_W'(p10_q) + OP_W'(p01_q);
      A_QA:      a_op = $signed({2'b00, qa_q});
      A_QB:      a_op = $signed({2'b00, qb_q});
      A_P11:     a_op = OP_W'(p11_q);
      A_K0:      a_op = OP_W'(k0_q);
      A_K1:      a_op = OP_W'(k1_q);
      default:   a_op = '0;
    endcase
    case (cmd_i.mul.b_sel)
      B_DT:    b_op = $signed({17'd0, dt_q});
      B_Y:     b_op = y_q;
      B_P00:   b_op = OP_W'(p00_q);
      B_P01:   b_op = OP_W'(p01_q);
      default: b_op = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_q <= '0;
    end else begin
      mul_q <= cmd_i.mul;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul.valid) begin
      prod_q <= PROD_W'(a_op) * PROD_W'(b_op);
    end
  end

  // round, accumulate, saturate
  logic signed [ACC_W-1:0] prod_x, term, sterm, base, acc_d, acc_q, dst_val;
  logic signed [31:0]      wr_val;

  assign prod_x = ACC_W'(prod_q);

  always_comb begin
    case (mul_q.dst)
      DST_ANGLE: dst_val = ACC_W'(angle_q);
      DST_BIAS:  dst_val = ACC_W'(bias_q);
      DST_P00:   dst_val = ACC_W'(p00_q);
      DST_P01:   dst_val = ACC_W'(p01_q);
      DST_P10:   dst_val = ACC_W'(p10_q);
      DST_P11:   dst_val = ACC_W'(p11_q);
      default:   dst_val = '0;
    endcase
    term   = mul_q.frac ? ((prod_x + HALF_FRAC) >>> FRACTION_BITS)
                        : ((prod_x + HALF_DT) >>> DT_BITS);
    sterm  = mul_q.neg ? -term : term;
    base   = mul_q.first ? dst_val : acc_q;
    acc_d  = base + sterm;
    wr_val = sat32(acc_d);
  end

  always_ff @(posedge clk_i) begin
    if (mul_q.valid) begin
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_q <= '0;
      bias_q  <= '0;
      p00_q   <= '0;
      p01_q   <= '0;
      p10_q   <= '0;
      p11_q   <= '0;
    end else if (mul_q.valid && mul_q.last) begin
      case (mul_q.dst)
        DST_ANGLE: angle_q <= wr_val;
        DST_BIAS:  bias_q  <= wr_val;
        DST_P00:   p00_q   <= wr_val;
        DST_P01:   p01_q   <= wr_val;
        DST_P10:   p10_q   <= wr_val;
        DST_P11:   p11_q   <= wr_val;
        default: ;
      endcase
    end
  end

  // output register
  gak_out_t out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.angle_estimate <= angle_q;
      out_q.bias_estimate  <= bias_q;
    end
  end

  assign out_data_o       = out_q;
  assign stat_o.is_update = upd_q;
  assign stat_o.s_pos     = !s_q[32] && (|s_q[31:0]);
  assign stat_o.div_busy  = busy_q;

endmodule

[hw/rtl/gyro_angle_kalman_filter.sv]
// ---------------------------------------------------------------------------
// gyro_angle_kalman_filter
// Two-state angle and gyro bias Kalman filter, fixed point, one shared
// multiplier and an iterative divider under a small sequencer.
// ---------------------------------------------------------------------------
//  channel   handshake               payload
//  in        in_valid_i / in_stall_o  in_data_i (command, rate, dt, angle)
//  out       out_valid_o / out_stall_i out_data_o (angle, bias estimates)
//  cfg       cfg_we_i                 cfg_index_i, cfg_data_i
//
//  Predict word: load, setup, six multiply steps, drain.
//  Update word: load and setup; the bit-serial divider (32 + FRACTION_BITS
//  steps, a finishing step and a handoff); then six multiply steps, drain
//  and output.
//  Update with S not positive: load, setup and output; estimates returned unchanged.
//  A new word is taken while a result still waits; a stalled result only
//  holds off the next update at its output step.
//  Reset clears state and restores the noise registers.
// ---------------------------------------------------------------------------
module gyro_angle_kalman_filter #(
  parameter int FRACTION_BITS = gak_pkg::FRACTION_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  gak_pkg::gak_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output gak_pkg::gak_out_t             out_data_o,
  input  logic                          cfg_we_i,
  input  logic [gak_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [gak_pkg::CFG_W-1:0]     cfg_data_i
);
  import gak_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  gak_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  gak_datapath #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule

[hw/rtl/gak_checker.sv]
// ---------------------------------------------------------------------------
// gak_checker
// Port-level checks on the filter's word flow, bound to the top level.
// ---------------------------------------------------------------------------
`include "gyro_angle_kalman_filter_assert.svh"

module gak_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input gak_pkg::gak_in_t in_data_i,
  input logic             out_valid_o,
  input logic             out_stall_i
);
  logic in_acc;
  logic upd_acc;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign upd_acc = in_acc && (in_data_i.command == gak_pkg::CMD_UPDATE);

  `GAK_ASSERT_ALWAYS(a_no_out_in_reset, !rst_ni |-> !out_valid_o, "result valid in reset")
  `GAK_ASSERT(a_out_holds, out_valid_o && out_stall_i |=> out_valid_o, "stalled result dropped")
  `GAK_ASSERT(a_busy_after_take, in_acc |=> in_stall_o, "second word taken while busy")
  `GAK_ASSERT(a_no_instant_out, upd_acc |=> !$rose(out_valid_o), "result without work cycles")

endmodule

bind gyro_angle_kalman_filter gak_checker u_gak_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i)
);
